// File: hdl/fcsr_pkg.sv
// ----------------------------------------------------------------------------
// fcsr_pkg
// Shared types and constants for the filled circle span rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsr_pkg;

  localparam int COLOR_BITS_DEFAULT  = 32;
  localparam int RADIUS_BITS_DEFAULT = 12;

  localparam int COORD_W  = 14;   // center coordinates, two's complement
  localparam int RADIUS_W = 12;   // radius field and walk registers
  localparam int PIX_W    = 12;   // row and column fields of a result
  localparam int CFG_W    = 13;   // screen size registers
  localparam int DEC_W    = 18;   // decision term, wraps
  localparam int CALC_W   = 16;   // signed width for center +/- offset

  localparam int NUM_SPAN   = 4;
  localparam int NUM_POINT  = 8;
  localparam int NUM_PLACE  = NUM_SPAN + NUM_POINT;
  localparam int NUM_RES    = NUM_PLACE + 1;
  localparam int STATUS_IDX = NUM_PLACE;
  localparam int SEL_W      = $clog2(NUM_RES);

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CFG_W-1:0] SCREEN_MAX   = 13'd4096;

  typedef enum logic [1:0] {
    KIND_SPAN   = 2'd0,
    KIND_POINT  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // one clipped span or point
  typedef struct packed {
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] x_first;
    logic [PIX_W-1:0] x_final;
  } place_t;

  // midpoint walk state
  typedef struct packed {
    logic [RADIUS_W-1:0]    x;
    logic [RADIUS_W-1:0]    y;
    logic signed [DEC_W-1:0] dec;
    logic                    active;
  } walk_t;

  // which results of one item exist, and the status flag
  typedef struct packed {
    logic [NUM_RES-1:0] valid;
    logic               done;
  } res_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/fcsr_calc.sv
// ----------------------------------------------------------------------------
// fcsr_calc
// One midpoint iteration: clips the four spans and eight outline points of
// the current walk position and gives the next state (the first on a start).
// ----------------------------------------------------------------------------
`default_nettype none

module fcsr_calc #(
  parameter int RADIUS_BITS = fcsr_pkg::RADIUS_BITS_DEFAULT
) (
  input  wire logic                                   op_step,
  input  wire logic [fcsr_pkg::RADIUS_W-1:0]          radius,
  input  wire logic signed [fcsr_pkg::COORD_W-1:0]    held_cx,
  input  wire logic signed [fcsr_pkg::COORD_W-1:0]    held_cy,
  input  wire fcsr_pkg::walk_t                        walk,
  input  wire logic [fcsr_pkg::CFG_W-1:0]             screen_width,
  input  wire logic [fcsr_pkg::CFG_W-1:0]             screen_height,
  output fcsr_pkg::place_t [fcsr_pkg::NUM_PLACE-1:0]  place,
  output fcsr_pkg::res_ctrl_t                         ctrl,
  output fcsr_pkg::walk_t                             walk_next
);

  localparam int CW = fcsr_pkg::CALC_W;
  localparam int RW = fcsr_pkg::RADIUS_W;
  localparam int DW = fcsr_pkg::DEC_W;
  localparam logic [RW-1:0] RADIUS_MASK =
    (RADIUS_BITS >= RW) ? {RW{1'b1}} : RW'((1 << RADIUS_BITS) - 1);

  typedef struct packed {
    logic             ok;
    fcsr_pkg::place_t p;
  } clip_t;

  function automatic clip_t clip_span(input logic signed [CW-1:0] r,
                                      input logic signed [CW-1:0] lo,
                                      input logic signed [CW-1:0] hi,
                                      input logic signed [CW-1:0] w,
                                      input logic signed [CW-1:0] h);
    clip_t c;
    logic signed [CW-1:0] lo_c;
    logic signed [CW-1:0] hi_c;
    lo_c = (lo < 0) ? '0 : lo;
    hi_c = (hi > w - CW'(1)) ? w - CW'(1) : hi;
    c.ok        = (r >= 0) && (r < h) && (lo_c <= hi_c);
    c.p.row     = r[fcsr_pkg::PIX_W-1:0];
    c.p.x_first = lo_c[fcsr_pkg::PIX_W-1:0];
    c.p.x_final = hi_c[fcsr_pkg::PIX_W-1:0];
    return c;
  endfunction

  function automatic clip_t clip_point(input logic signed [CW-1:0] px,
                                       input logic signed [CW-1:0] py,
                                       input logic signed [CW-1:0] w,
                                       input logic signed [CW-1:0] h);
    clip_t c;
    c.ok        = (px >= 0) && (px < w) && (py >= 0) && (py < h);
    c.p.row     = py[fcsr_pkg::PIX_W-1:0];
    c.p.x_first = px[fcsr_pkg::PIX_W-1:0];
    c.p.x_final = px[fcsr_pkg::PIX_W-1:0];
    return c;
  endfunction

  logic [fcsr_pkg::CFG_W-1:0] eff_w;
  logic [fcsr_pkg::CFG_W-1:0] eff_h;
  logic signed [CW-1:0]       sw;
  logic signed [CW-1:0]       sh;
  logic signed [CW-1:0]       cx;
  logic signed [CW-1:0]       cy;
  logic signed [CW-1:0]       xs;
  logic signed [CW-1:0]       ys;
  clip_t                      res [fcsr_pkg::NUM_PLACE];

  logic [RW-1:0]              r;
  logic                       dec_neg;
  logic signed [RW+1:0]       diff;
  logic signed [RW+1:0]       x_inc;
  logic signed [RW+1:0]       y_dec;
  logic signed [DW-1:0]       dec_step;

  always_comb begin
    eff_w = (screen_width > fcsr_pkg::SCREEN_MAX) ? fcsr_pkg::SCREEN_MAX : screen_width;
    eff_h = (screen_height > fcsr_pkg::SCREEN_MAX) ? fcsr_pkg::SCREEN_MAX : screen_height;
    sw = $signed(CW'(eff_w));
    sh = $signed(CW'(eff_h));
    cx = CW'(held_cx);
    cy = CW'(held_cy);
    xs = $signed(CW'(walk.x));
    ys = $signed(CW'(walk.y));

    res[0]  = clip_span(cy + ys, cx - xs, cx + xs, sw, sh);
    res[1]  = clip_span(cy - ys, cx - xs, cx + xs, sw, sh);
    res[2]  = clip_span(cy - xs, cx - ys, cx + ys, sw, sh);
    res[3]  = clip_span(cy + xs, cx - ys, cx + ys, sw, sh);
    res[4]  = clip_point(cx + xs, cy + ys, sw, sh);
    res[5]  = clip_point(cx - xs, cy + ys, sw, sh);
    res[6]  = clip_point(cx + xs, cy - ys, sw, sh);
    res[7]  = clip_point(cx - xs, cy - ys, sw, sh);
    res[8]  = clip_point(cx + ys, cy + xs, sw, sh);
    res[9]  = clip_point(cx - ys, cy + xs, sw, sh);
    res[10] = clip_point(cx + ys, cy - xs, sw, sh);
    res[11] = clip_point(cx - ys, cy - xs, sw, sh);
  end

  // decision update and walk advance
  always_comb begin
    r        = radius & RADIUS_MASK;
    dec_neg  = walk.dec[DW-1];
    diff     = $signed({2'b00, walk.x}) - $signed({2'b00, walk.y});
    x_inc    = $signed({2'b00, walk.x}) + (RW+2)'(1);
    y_dec    = $signed({2'b00, walk.y}) - (dec_neg ? (RW+2)'(0) : (RW+2)'(1));
    if (dec_neg) begin
      dec_step = walk.dec + $signed(DW'({walk.x, 2'b00})) + DW'(6);
    end else begin
      // x - y is not positive here, so keep its sign
      dec_step = walk.dec + DW'($signed({diff, 2'b00})) + DW'(10);
    end

    walk_next = walk;
    if (!op_step) begin
      walk_next.x      = '0;
      walk_next.y      = r;
      walk_next.dec    = DW'(3) - $signed(DW'({r, 1'b0}));
      walk_next.active = 1'b1;
    end else if (walk.active) begin
      walk_next.x      = x_inc[RW-1:0];
      walk_next.y      = y_dec[RW-1:0];
      walk_next.dec    = dec_step;
      walk_next.active = !(x_inc > y_dec);
    end
  end

  always_comb begin
    ctrl.valid = '0;
    ctrl.valid[fcsr_pkg::STATUS_IDX] = 1'b1;
    for (int i = 0; i < fcsr_pkg::NUM_PLACE; i++) begin
      place[i] = res[i].p;
      if (op_step && walk.active) begin
        ctrl.valid[i] = res[i].ok;
      end
    end
    ctrl.done = op_step && !walk_next.active;
  end

endmodule

`default_nettype wire

// File: hdl/filled_circle_span_rasterizer.sv
// ----------------------------------------------------------------------------
// filled_circle_span_rasterizer
// Midpoint circle walker that emits clipped fill spans, outline points and a
// status item for every step.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         tvalid/tready      start or step item (tuser: operation)
//  m_*       out        tvalid/tready      span, point or status (tlast)
//  cfg_*     in         cfg_wr_en          screen width / height
//
//  An accepted item sits in the input register and, once the result bank is
//  empty, its whole result set (up to twelve places plus status) is written
//  into the bank together; the first result is offered from the bank, which
//  is registered after the input register. While m_tready is high the bank
//  drains one result per cycle, so a step item yields 1 to 13 results and a
//  start item one; the next item is taken in the cycle the last result leaves.
//  An output stall holds the bank and the input register, and drops s_tready
//  once the input register is full. Reset is synchronous and leaves the walk idle.
// ----------------------------------------------------------------------------
`default_nettype none

module filled_circle_span_rasterizer #(
  parameter int COLOR_BITS  = fcsr_pkg::COLOR_BITS_DEFAULT,
  parameter int RADIUS_BITS = fcsr_pkg::RADIUS_BITS_DEFAULT,
  localparam int IN_BITS    = 2 * fcsr_pkg::COORD_W + fcsr_pkg::RADIUS_W + 2 * COLOR_BITS,
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = 3 * fcsr_pkg::PIX_W + COLOR_BITS + 1,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // center_x, center_y, radius, fill_color, outline_color
  input  wire logic [IN_W-1:0]               s_tdata,
  // operation
  input  wire logic                          s_tuser,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // row, x_first, x_final, color, done_res
  output logic [OUT_W-1:0]                   m_tdata,
  // kind
  output logic [1:0]                         m_tuser,
  output logic                               m_tlast,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_index,
  input  wire logic [fcsr_pkg::CFG_W-1:0]    cfg_data
);

  localparam int CB = COLOR_BITS;
  localparam int CW = fcsr_pkg::COORD_W;
  localparam int RW = fcsr_pkg::RADIUS_W;
  localparam int OFS_CX   = 0;
  localparam int OFS_CY   = OFS_CX + CW;
  localparam int OFS_RAD  = OFS_CY + CW;
  localparam int OFS_FILL = OFS_RAD + RW;
  localparam int OFS_OUTL = OFS_FILL + CB;
  localparam logic [fcsr_pkg::NUM_RES-1:0] STATUS_ONLY =
    fcsr_pkg::NUM_RES'(1) << fcsr_pkg::STATUS_IDX;

  // configuration
  logic [fcsr_pkg::CFG_W-1:0] screen_width;
  logic [fcsr_pkg::CFG_W-1:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= fcsr_pkg::WIDTH_RESET;
      screen_height <= fcsr_pkg::HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fcsr_pkg::REG_WIDTH:  screen_width  <= cfg_data;
        fcsr_pkg::REG_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                  a_valid;
  logic                  a_op;
  logic signed [CW-1:0]  a_cx;
  logic signed [CW-1:0]  a_cy;
  logic [RW-1:0]         a_rad;
  logic [CB-1:0]         a_fill;
  logic [CB-1:0]         a_outline;

  // circle state
  logic signed [CW-1:0]  held_cx;
  logic signed [CW-1:0]  held_cy;
  logic [CB-1:0]         held_fill;
  logic [CB-1:0]         held_outline;
  fcsr_pkg::walk_t       walk;
  fcsr_pkg::walk_t       walk_next;

  // result bank
  logic [fcsr_pkg::NUM_RES-1:0]                 bank_valid;
  logic [fcsr_pkg::NUM_RES-1:0]                 bank_valid_next;
  fcsr_pkg::place_t [fcsr_pkg::NUM_PLACE-1:0]   bank_place;
  logic [CB-1:0]                                bank_fill;
  logic [CB-1:0]                                bank_outline;
  logic                                         bank_done;

  fcsr_pkg::place_t [fcsr_pkg::NUM_PLACE-1:0]   calc_place;
  fcsr_pkg::res_ctrl_t                          calc_ctrl;

  logic                          take;
  logic                          bank_free;
  logic                          load;
  logic [fcsr_pkg::SEL_W-1:0]    sel;
  fcsr_pkg::place_t              sel_place;
  fcsr_pkg::kind_t               sel_kind;
  logic [CB-1:0]                 sel_color;

  fcsr_calc #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_calc (
    .op_step       (a_op),
    .radius        (a_rad),
    .held_cx       (held_cx),
    .held_cy       (held_cy),
    .walk          (walk),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .place         (calc_place),
    .ctrl          (calc_ctrl),
    .walk_next     (walk_next)
  );

  // drop the lowest pending result on each output transaction
  always_comb begin
    take            = m_tvalid && m_tready;
    bank_valid_next = take ? (bank_valid & (bank_valid - fcsr_pkg::NUM_RES'(1)))
                           : bank_valid;
    bank_free       = (bank_valid_next == '0);
    load            = a_valid && bank_free;
    s_tready        = !a_valid || bank_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      a_valid <= 1'b1;
    end else if (load) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_op      <= s_tuser;
      a_cx      <= $signed(s_tdata[OFS_CX +: CW]);
      a_cy      <= $signed(s_tdata[OFS_CY +: CW]);
      a_rad     <= s_tdata[OFS_RAD +: RW];
      a_fill    <= s_tdata[OFS_FILL +: CB];
      a_outline <= s_tdata[OFS_OUTL +: CB];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk         <= '0;
      held_cx      <= '0;
      held_cy      <= '0;
      held_fill    <= '0;
      held_outline <= '0;
    end else if (load) begin
      walk <= walk_next;
      if (a_op == fcsr_pkg::OP_START) begin
        held_cx      <= a_cx;
        held_cy      <= a_cy;
        held_fill    <= a_fill;
        held_outline <= a_outline;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_valid <= '0;
    end else if (load) begin
      bank_valid <= calc_ctrl.valid;
    end else begin
      bank_valid <= bank_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bank_place   <= calc_place;
      bank_fill    <= held_fill;
      bank_outline <= held_outline;
      bank_done    <= calc_ctrl.done;
    end
  end

  // lowest pending result goes out first
  always_comb begin
    sel = fcsr_pkg::SEL_W'(fcsr_pkg::STATUS_IDX);
    for (int i = fcsr_pkg::NUM_RES - 1; i >= 0; i--) begin
      if (bank_valid[i]) begin
        sel = fcsr_pkg::SEL_W'(i);
      end
    end

    if (sel == fcsr_pkg::SEL_W'(fcsr_pkg::STATUS_IDX)) begin
      sel_kind  = fcsr_pkg::KIND_STATUS;
      sel_place = '0;
      sel_color = '0;
    end else if (sel >= fcsr_pkg::SEL_W'(fcsr_pkg::NUM_SPAN)) begin
      sel_kind  = fcsr_pkg::KIND_POINT;
      sel_place = bank_place[sel];
      sel_color = bank_outline;
    end else begin
      sel_kind  = fcsr_pkg::KIND_SPAN;
      sel_place = bank_place[sel];
      sel_color = bank_fill;
    end

    m_tvalid = |bank_valid;
    m_tuser  = sel_kind;
    m_tlast  = (sel_kind == fcsr_pkg::KIND_STATUS);
    m_tdata  = OUT_W'({(m_tlast && bank_done), sel_color, sel_place.x_final,
                       sel_place.x_first, sel_place.row});
  end

`ifndef SYNTHESIS
  // every item loaded into the bank ends in a status result
  a_load_status: assert property (@(posedge clk) disable iff (rst)
    load |=> bank_valid[fcsr_pkg::STATUS_IDX])
    else $error("result bank loaded without a status result");

  // a step while idle yields the status result alone, flagged done
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (load && a_op == fcsr_pkg::OP_STEP && !walk.active)
      |=> (bank_valid == STATUS_ONLY) && bank_done)
    else $error("idle step produced more than a done status");

  // a start arms the walk and reports not done
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (load && a_op == fcsr_pkg::OP_START)
      |=> walk.active && (bank_valid == STATUS_ONLY) && !bank_done)
    else $error("start item did not arm the walk");

  // the walk never moves unless an item is loaded
  a_walk_hold: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(walk))
    else $error("walk state changed without an item");

  // the bank is only refilled once its last result is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !load)
    else $error("result bank reloaded over pending results");
`endif

endmodule

`default_nettype wire
